// ----- hw/rtl/life_grid_generation_step_macros.svh -----
// Assertion macros for the life grid generation step block.
// Included by files that carry concurrent assertions; depends on nothing else.
`ifndef LIFE_GRID_GENERATION_STEP_MACROS_SVH
`define LIFE_GRID_GENERATION_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LGS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/lgs_pkg.sv -----
// Shared types, constants and helper functions for the life grid block.
// Used by the row memory, the cell rule unit and the top level.
package lgs_pkg;

   localparam int MAX_COLS = 128;
   localparam int MAX_ROWS = 128;

   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
   localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

   localparam int FUNC_W     = 2;
   localparam int COORD_W    = 7;
   localparam int CELL_W     = 2;
   localparam int GEN_W      = 32;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;

   typedef logic [CELL_W-1:0] cell_type;
   typedef cell_type [MAX_COLS-1:0] row_type;

   localparam cell_type CELL_EMPTY    = 2'd0;
   localparam cell_type CELL_ALIVE    = 2'd1;
   localparam cell_type CELL_ONCE     = 2'd2;
   localparam cell_type CELL_RESERVED = 2'd3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_STEP  = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLS = 1'b0,
      CSR_ROWS = 1'b1
   } csr_type;

   typedef struct packed {
      logic             wr_en;
      logic [ROW_W-1:0] wr_addr;
      logic             rd_en;
      logic [ROW_W-1:0] rd_addr;
   } ram_ctl_type;

   // Bit 0 of above and below is the left column, bit 1 the centre, bit 2 the right.
   typedef struct packed {
      logic [2:0] above;
      logic [2:0] below;
      logic       side_l;
      logic       side_r;
      logic       has_left;
      logic       has_right;
      cell_type   centre;
   } nbhd_type;

   function automatic logic [COL_CNT_W-1:0] clamp_cols(input logic [CSR_DATA_W-1:0] v);
      logic [COL_CNT_W-1:0] res;
      if (v == '0) begin
         res = COL_CNT_W'(1);
      end else if (32'(v) > MAX_COLS) begin
         res = COL_CNT_W'(MAX_COLS);
      end else begin
         res = COL_CNT_W'(v);
      end
      return res;
   endfunction

   function automatic logic [ROW_CNT_W-1:0] clamp_rows(input logic [CSR_DATA_W-1:0] v);
      logic [ROW_CNT_W-1:0] res;
      if (v == '0) begin
         res = ROW_CNT_W'(1);
      end else if (32'(v) > MAX_ROWS) begin
         res = ROW_CNT_W'(MAX_ROWS);
      end else begin
         res = ROW_CNT_W'(v);
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/lgs_row_ram.sv -----
// Grid memory holding one row of cells per word, one write and one read port.
// Read data is registered. Depends on lgs_pkg.
module lgs_row_ram (
   input  logic                clock,
   input  lgs_pkg::ram_ctl_type ctl,
   input  lgs_pkg::row_type     wr_data,
   output lgs_pkg::row_type     rd_data
);
   import lgs_pkg::*;

   row_type mem_ff [MAX_ROWS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lgs_cell_rule.sv -----
// Shared cell rule unit: counts live neighbours inside the grid edges and
// gives the next value of one cell. Depends on lgs_pkg.
module lgs_cell_rule (
   input  lgs_pkg::nbhd_type nbhd,
   output lgs_pkg::cell_type cell_next
);
   import lgs_pkg::*;

   logic [2:0] above_m;
   logic [2:0] below_m;
   logic       left_m;
   logic       right_m;
   logic [3:0] live_count;

   assign above_m = nbhd.above & {nbhd.has_right, 1'b1, nbhd.has_left};
   assign below_m = nbhd.below & {nbhd.has_right, 1'b1, nbhd.has_left};
   assign left_m  = nbhd.side_l & nbhd.has_left;
   assign right_m = nbhd.side_r & nbhd.has_right;

   assign live_count = 4'(above_m[0]) + 4'(above_m[1]) + 4'(above_m[2])
                     + 4'(below_m[0]) + 4'(below_m[1]) + 4'(below_m[2])
                     + 4'(left_m) + 4'(right_m);

   always_comb begin
      cell_next = nbhd.centre;
      if (nbhd.centre != CELL_ALIVE && live_count == 4'd3) begin
         cell_next = CELL_ALIVE;
      end else if (nbhd.centre == CELL_ALIVE && (live_count < 4'd2 || live_count > 4'd3)) begin
         cell_next = CELL_ONCE;
      end
   end

endmodule

// ----- hw/rtl/life_grid_generation_step.sv -----
// Bounded Game of Life grid with three cell values: a read or write of one
// cell goes from acceptance through the read or write state and the output
// state to the registered result word, skipping the read or write state when
// the coordinate lies outside the grid in use, the written value is the
// reserved one or the operation is unused. A generation step works row by row:
// one evaluation of the shared cell rule unit per cell and one row read and one
// row write of the grid memory per row. A stalled result word that still waits
// on the output holds the next one back for as long as the stall lasts. The
// block takes one word at a time and may accept the next word while a finished
// result word still waits on the output. After reset a clearing pass over all
// MAX_ROWS (128) rows zeroes the grid; no word is accepted then, while
// configuration writes are taken at any time.
// Depends on lgs_pkg, lgs_row_ram, lgs_cell_rule and the assertion macros.
`include "life_grid_generation_step_macros.svh"

module life_grid_generation_step (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lgs_pkg::FUNC_W-1:0]        req_func,
   input  logic [lgs_pkg::COORD_W-1:0]       req_col,
   input  logic [lgs_pkg::COORD_W-1:0]       req_row,
   input  logic [lgs_pkg::CELL_W-1:0]        req_cell_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lgs_pkg::CELL_W-1:0]        rsp_cell_out,
   output logic [lgs_pkg::GEN_W-1:0]         rsp_generation,
   output logic                              rsp_bad_coord,
   input  logic                              csr_write_en,
   input  logic [lgs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lgs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lgs_pkg::*;

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_RD      = 9'b000000100,
      ST_WR      = 9'b000001000,
      ST_G_LOAD  = 9'b000010000,
      ST_G_FETCH = 9'b000100000,
      ST_G_CELL  = 9'b001000000,
      ST_G_WRITE = 9'b010000000,
      ST_OUT     = 9'b100000000
   } state_type;

   state_type               state_ff, state_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [COL_W-1:0]        col_ff, col_in;
   cell_type                op_cell_ff, op_cell_in;
   logic [MAX_COLS-1:0]     up_ff, up_in;
   row_type                 mid_ff, mid_in;
   row_type                 dn_ff, dn_in;
   row_type                 nrow_ff, nrow_in;
   cell_type                res_cell_ff, res_cell_in;
   logic                    res_bad_ff, res_bad_in;
   logic [GEN_W-1:0]        gen_ff, gen_in;
   logic [CSR_DATA_W-1:0]   cols_ff, cols_in;
   logic [CSR_DATA_W-1:0]   rows_ff, rows_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   cell_type                rsp_cell_out_ff, rsp_cell_out_in;
   logic [GEN_W-1:0]        rsp_generation_ff, rsp_generation_in;
   logic                    rsp_bad_coord_ff, rsp_bad_coord_in;

   logic [COL_CNT_W-1:0]    nc;
   logic [ROW_CNT_W-1:0]    nr;
   logic                    coord_bad;
   logic                    out_free;
   logic                    has_left;
   logic                    has_right;
   logic [COL_W-1:0]        idx_l;
   logic [COL_W-1:0]        idx_r;
   nbhd_type                nbhd;
   cell_type                cell_next;
   ram_ctl_type             ram_ctl;
   row_type                 ram_wdata;
   row_type                 ram_rdata;
   logic                    gen_cell;
   logic                    gen_scan;
   logic                    gen_last;
   logic                    col_fits;
   logic                    row_fits;
   logic                    out_held;
   logic [GEN_W-1:0]        gen_inc;

   function automatic logic [MAX_COLS-1:0] row_live(input row_type r);
      logic [MAX_COLS-1:0] l;
      for (int i = 0; i < MAX_COLS; i++) begin
         l[i] = (r[i] == CELL_ALIVE);
      end
      return l;
   endfunction

   lgs_row_ram u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   lgs_cell_rule u_rule (
      .nbhd      (nbhd),
      .cell_next (cell_next)
   );

   assign nc        = clamp_cols(cols_ff);
   assign nr        = clamp_rows(rows_ff);
   assign coord_bad = (32'(req_col) >= 32'(nc)) || (32'(req_row) >= 32'(nr));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign has_left  = (col_ff != '0);
   assign has_right = (32'(col_ff) + 32'd1 < 32'(nc));
   assign idx_l     = has_left ? col_ff - COL_W'(1) : col_ff;
   assign idx_r     = has_right ? col_ff + COL_W'(1) : col_ff;

   always_comb begin
      nbhd.above     = {up_ff[idx_r], up_ff[col_ff], up_ff[idx_l]};
      nbhd.below     = {dn_ff[idx_r] == CELL_ALIVE, dn_ff[col_ff] == CELL_ALIVE,
                        dn_ff[idx_l] == CELL_ALIVE};
      nbhd.side_l    = (mid_ff[idx_l] == CELL_ALIVE);
      nbhd.side_r    = (mid_ff[idx_r] == CELL_ALIVE);
      nbhd.has_left  = has_left;
      nbhd.has_right = has_right;
      nbhd.centre    = mid_ff[col_ff];
   end

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      op_cell_in  = op_cell_ff;
      up_in       = up_ff;
      mid_in      = mid_ff;
      dn_in       = dn_ff;
      nrow_in     = nrow_ff;
      res_cell_in = res_cell_ff;
      res_bad_in  = res_bad_ff;
      gen_in      = gen_ff;
      ram_ctl     = '0;
      ram_wdata   = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = row_ff;
            if (32'(row_ff) == MAX_ROWS - 1) begin
               row_in   = '0;
               state_in = ST_IDLE;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               col_in      = COL_W'(req_col);
               row_in      = ROW_W'(req_row);
               op_cell_in  = req_cell_in;
               res_cell_in = CELL_EMPTY;
               res_bad_in  = 1'b0;
               case (func_type'(req_func))
                  FUNC_WRITE: begin
                     if (coord_bad) begin
                        res_bad_in = 1'b1;
                        state_in   = ST_OUT;
                     end else if (req_cell_in == CELL_RESERVED) begin
                        state_in = ST_OUT;
                     end else begin
                        ram_ctl.rd_en   = 1'b1;
                        ram_ctl.rd_addr = ROW_W'(req_row);
                        state_in        = ST_WR;
                     end
                  end
                  FUNC_READ: begin
                     if (coord_bad) begin
                        res_bad_in = 1'b1;
                        state_in   = ST_OUT;
                     end else begin
                        ram_ctl.rd_en   = 1'b1;
                        ram_ctl.rd_addr = ROW_W'(req_row);
                        state_in        = ST_RD;
                     end
                  end
                  FUNC_STEP: begin
                     ram_ctl.rd_en   = 1'b1;
                     ram_ctl.rd_addr = '0;
                     row_in          = '0;
                     state_in        = ST_G_LOAD;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_RD: begin
            res_cell_in = ram_rdata[col_ff];
            state_in    = ST_OUT;
         end
         ST_WR: begin
            ram_wdata         = ram_rdata;
            ram_wdata[col_ff] = op_cell_ff;
            ram_ctl.wr_en     = 1'b1;
            ram_ctl.wr_addr   = row_ff;
            state_in          = ST_OUT;
         end
         ST_G_LOAD: begin
            mid_in          = ram_rdata;
            up_in           = '0;
            ram_ctl.rd_en   = (32'(nr) > 32'd1);
            ram_ctl.rd_addr = ROW_W'(1);
            state_in        = ST_G_FETCH;
         end
         ST_G_FETCH: begin
            dn_in    = (32'(row_ff) + 32'd1 < 32'(nr)) ? ram_rdata : '0;
            nrow_in  = mid_ff;
            col_in   = '0;
            state_in = ST_G_CELL;
         end
         ST_G_CELL: begin
            nrow_in[col_ff] = cell_next;
            if (32'(col_ff) + 32'd1 == 32'(nc)) begin
               state_in = ST_G_WRITE;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_G_WRITE: begin
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = row_ff;
            ram_wdata       = nrow_ff;
            up_in           = row_live(mid_ff);
            mid_in          = dn_ff;
            if (32'(row_ff) + 32'd1 == 32'(nr)) begin
               gen_in   = gen_ff + GEN_W'(1);
               state_in = ST_OUT;
            end else begin
               row_in          = row_ff + ROW_W'(1);
               ram_ctl.rd_en   = (32'(row_ff) + 32'd2 < 32'(nr));
               ram_ctl.rd_addr = ROW_W'(32'(row_ff) + 32'd2);
               state_in        = ST_G_FETCH;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_write_en) begin
         case (csr_type'(csr_index))
            CSR_COLS: cols_in = csr_wdata;
            CSR_ROWS: rows_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_cell_out_in   = rsp_cell_out_ff;
      rsp_generation_in = rsp_generation_ff;
      rsp_bad_coord_in  = rsp_bad_coord_ff;
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in      = 1'b1;
         rsp_cell_out_in   = res_cell_ff;
         rsp_generation_in = gen_ff;
         rsp_bad_coord_in  = res_bad_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         gen_ff       <= '0;
         cols_ff      <= CSR_DATA_W'(MAX_COLS);
         rows_ff      <= CSR_DATA_W'(MAX_ROWS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         gen_ff       <= gen_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff            <= col_in;
      op_cell_ff        <= op_cell_in;
      up_ff             <= up_in;
      mid_ff            <= mid_in;
      dn_ff             <= dn_in;
      nrow_ff           <= nrow_in;
      res_cell_ff       <= res_cell_in;
      res_bad_ff        <= res_bad_in;
      rsp_cell_out_ff   <= rsp_cell_out_in;
      rsp_generation_ff <= rsp_generation_in;
      rsp_bad_coord_ff  <= rsp_bad_coord_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_out   = rsp_cell_out_ff;
   assign rsp_generation = rsp_generation_ff;
   assign rsp_bad_coord  = rsp_bad_coord_ff;

   assign gen_cell = (state_ff == ST_G_CELL);
   assign gen_scan = state_ff inside {ST_G_FETCH, ST_G_CELL, ST_G_WRITE};
   assign gen_last = (state_ff == ST_G_WRITE) && (32'(row_ff) + 32'd1 == 32'(nr));
   assign col_fits = (32'(col_ff) < 32'(nc));
   assign row_fits = (32'(row_ff) < 32'(nr));
   assign out_held = (state_ff == ST_OUT) && rsp_valid_ff && rsp_stall;
   assign gen_inc  = gen_ff + GEN_W'(1);

   `LGS_ASSERT_IMPLIES(a_col_in_grid, clock, reset, gen_cell, col_fits, "column scan out of range")
   `LGS_ASSERT_IMPLIES(a_row_in_grid, clock, reset, gen_scan, row_fits, "row scan out of range")
   `LGS_ASSERT_NEXT(a_gen_once, clock, reset, gen_last, gen_ff == $past(gen_inc), "counter not advanced")
   `LGS_ASSERT_NEXT(a_result_held, clock, reset, out_held, state_ff == ST_OUT, "pending result dropped")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the bounded three-value life grid block.
// It drives cell writes, reads and generation steps through valid/stall handshakes and
// checks every result word against its own grid model; depends only on lgs_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import lgs_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
   localparam int COORD_TOP = (1 << COORD_W) - 1;
   localparam int QUIET_LIMIT = 100000;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      cell_type           cell_in;
   } grid_cmd_type;

   typedef struct packed {
      cell_type         cell_out;
      logic [GEN_W-1:0] generation;
      logic             bad_coord;
   } grid_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FUNC_W-1:0]     req_func = '0;
   logic [COORD_W-1:0]    req_col = '0;
   logic [COORD_W-1:0]    req_row = '0;
   logic [CELL_W-1:0]     req_cell_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CELL_W-1:0]     rsp_cell_out;
   logic [GEN_W-1:0]      rsp_generation;
   logic                  rsp_bad_coord;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   grid_cmd_type   pending_cmds[$];
   grid_reply_type expected_replies[$];
   int             open_words = 0;
   int             fault_count = 0;
   int             quiet_cycles = 0;
   int             send_idle_pct = 9;
   int             recv_idle_pct = 60;
   bit             word_taken = 1'b0;

   cell_type               life_now [MAX_ROWS][MAX_COLS];
   cell_type               life_next [MAX_ROWS][MAX_COLS];
   logic [CSR_DATA_W-1:0]  cols_reg = 8'd128;
   logic [CSR_DATA_W-1:0]  rows_reg = 8'd128;
   logic [GEN_W-1:0]       gen_now = '0;

   life_grid_generation_step dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_col(req_col),
      .req_row(req_row),
      .req_cell_in(req_cell_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cell_out(rsp_cell_out),
      .rsp_generation(rsp_generation),
      .rsp_bad_coord(rsp_bad_coord),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int used_span(input logic [CSR_DATA_W-1:0] v, input int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic int live_around(input int r, input int c, input int nr, input int nc);
      int n;
      n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < nr && c + dc >= 0 &&
                c + dc < nc && life_now[r + dr][c + dc] == CELL_ALIVE) begin
               n++;
            end
         end
      end
      return n;
   endfunction

   function automatic void advance_generation(input int nr, input int nc);
      int n;
      life_next = life_now;
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            n = live_around(r, c, nr, nc);
            if (life_now[r][c] != CELL_ALIVE && n == 3) begin
               life_next[r][c] = CELL_ALIVE;
            end else if (life_now[r][c] == CELL_ALIVE && (n < 2 || n > 3)) begin
               life_next[r][c] = CELL_ONCE;
            end
         end
      end
      life_now = life_next;
      gen_now = gen_now + 1'b1;
   endfunction

   function automatic grid_reply_type predict_reply(input grid_cmd_type cmd);
      grid_reply_type rep;
      int nc;
      int nr;
      rep = '0;
      nc = used_span(cols_reg, MAX_COLS);
      nr = used_span(rows_reg, MAX_ROWS);
      case (cmd.func)
         FUNC_WRITE, FUNC_READ: begin
            if (int'(cmd.col) >= nc || int'(cmd.row) >= nr) begin
               rep.bad_coord = 1'b1;
            end else if (cmd.func == FUNC_WRITE) begin
               if (cmd.cell_in != CELL_RESERVED) begin
                  life_now[cmd.row][cmd.col] = cmd.cell_in;
               end
            end else begin
               rep.cell_out = life_now[cmd.row][cmd.col];
            end
         end
         FUNC_STEP: begin
            advance_generation(nr, nc);
         end
         default: begin
         end
      endcase
      rep.generation = gen_now;
      return rep;
   endfunction

   function automatic void note_fault(input string what, input grid_reply_type want,
                                      input grid_reply_type got);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t: %s: expected cell %0d gen %0d bad %0d, got cell %0d gen %0d bad %0d",
                  $time, what, want.cell_out, want.generation, want.bad_coord,
                  got.cell_out, got.generation, got.bad_coord);
      end
   endfunction

   function automatic void add_cmd(input logic [FUNC_W-1:0] func, input int col,
                                   input int row, input cell_type value);
      grid_cmd_type cmd;
      cmd.func = func;
      cmd.col = COORD_W'(col);
      cmd.row = COORD_W'(row);
      cmd.cell_in = value;
      pending_cmds.push_back(cmd);
      open_words++;
   endfunction

   function automatic int pick_coord(input int span);
      if ($urandom_range(9) == 0) return int'($urandom_range(COORD_TOP));
      return int'($urandom_range(span - 1));
   endfunction

   // Seeding writes dominate so that the small grids fill with live cells and steps
   // produce births and deaths; reads then observe them. Stray coordinates, the
   // reserved value and the unused operation are mixed in as noise.
   function automatic void add_random_cmds(input int count);
      int nc;
      int nr;
      int pick;
      cell_type value;
      nc = used_span(cols_reg, MAX_COLS);
      nr = used_span(rows_reg, MAX_ROWS);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         value = cell_type'($urandom_range(3));
         if (pick < 40) begin
            if ($urandom_range(2) != 0) value = CELL_ALIVE;
            add_cmd(FUNC_WRITE, pick_coord(nc), pick_coord(nr), value);
         end else if (pick < 75) begin
            add_cmd(FUNC_READ, pick_coord(nc), pick_coord(nr), value);
         end else if (pick < 92) begin
            add_cmd(FUNC_STEP, pick_coord(nc), pick_coord(nr), value);
         end else begin
            add_cmd(FUNC_NOP, pick_coord(nc), pick_coord(nr), value);
         end
      end
   endfunction

   task automatic wait_drained();
      while (open_words != 0) @(negedge clock);
   endtask

   task automatic set_size(input csr_type which, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      if (which == CSR_COLS) begin
         cols_reg = value;
      end else begin
         rows_reg = value;
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic resize(input logic [CSR_DATA_W-1:0] cols, input logic [CSR_DATA_W-1:0] rows,
                         input int send_pct, input int recv_pct);
      wait_drained();
      set_size(CSR_COLS, cols);
      set_size(CSR_ROWS, rows);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      @(posedge clock);
   endtask

   always @(negedge clock) begin : drive_words
      grid_cmd_type cmd;
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!reset && (!req_valid || word_taken)) begin
         word_taken = 1'b0;
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cmd = pending_cmds.pop_front();
            req_valid <= 1'b1;
            req_func <= cmd.func;
            req_col <= cmd.col;
            req_row <= cmd.row;
            req_cell_in <= cmd.cell_in;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch_words
      grid_reply_type want;
      grid_reply_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            word_taken = 1'b1;
            expected_replies.push_back(predict_reply({req_func, req_col, req_row, req_cell_in}));
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_cell_out, rsp_generation, rsp_bad_coord};
            if (expected_replies.size() == 0) begin
               note_fault("result word with nothing expected", '0, got);
            end else begin
               want = expected_replies.pop_front();
               open_words--;
               if (want !== got) begin
                  note_fault("result word mismatch", want, got);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      life_now = '{default: '{default: CELL_EMPTY}};
      life_next = '{default: '{default: CELL_EMPTY}};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full grid: corners, the reserved value, a blinker and lone cells dying.
      add_cmd(FUNC_WRITE, 0, 0, CELL_ALIVE);
      add_cmd(FUNC_WRITE, COORD_TOP, COORD_TOP, CELL_ALIVE);
      add_cmd(FUNC_WRITE, COORD_TOP, 0, CELL_ONCE);
      add_cmd(FUNC_WRITE, 0, COORD_TOP, CELL_ALIVE);
      add_cmd(FUNC_WRITE, 0, COORD_TOP, CELL_RESERVED);
      add_cmd(FUNC_READ, 0, COORD_TOP, CELL_EMPTY);
      add_cmd(FUNC_WRITE, 64, 63, CELL_ALIVE);
      add_cmd(FUNC_WRITE, 64, 64, CELL_ALIVE);
      add_cmd(FUNC_WRITE, 64, 65, CELL_ALIVE);
      add_cmd(FUNC_STEP, 0, 0, CELL_EMPTY);
      add_cmd(FUNC_READ, 63, 64, CELL_EMPTY);
      add_cmd(FUNC_READ, 64, 63, CELL_EMPTY);
      add_cmd(FUNC_READ, 64, 64, CELL_EMPTY);
      add_cmd(FUNC_READ, 0, 0, CELL_EMPTY);
      add_cmd(FUNC_READ, COORD_TOP, 0, CELL_EMPTY);
      add_cmd(FUNC_READ, COORD_TOP, COORD_TOP, CELL_EMPTY);
      add_cmd(FUNC_NOP, COORD_TOP, COORD_TOP, CELL_RESERVED);

      resize(8'd6, 8'd5, 9, 60);
      add_cmd(FUNC_WRITE, 6, 0, CELL_ALIVE);
      add_cmd(FUNC_READ, 0, 5, CELL_EMPTY);
      add_cmd(FUNC_WRITE, COORD_TOP, COORD_TOP, CELL_EMPTY);
      add_cmd(FUNC_READ, 5, 4, CELL_EMPTY);
      add_random_cmds(19);

      resize(8'd0, 8'd255, 60, 9);
      add_random_cmds(19);

      resize(8'd200, 8'd2, 60, 9);
      add_random_cmds(19);

      resize(8'($urandom_range(12, 3)), 8'($urandom_range(12, 3)), 0, 0);
      add_random_cmds(19);

      // Back to the full grid: cells left alone while it was shrunk must reappear.
      resize(8'd128, 8'd128, 0, 0);
      add_cmd(FUNC_READ, COORD_TOP, COORD_TOP, CELL_EMPTY);
      add_cmd(FUNC_READ, 0, COORD_TOP, CELL_EMPTY);
      add_cmd(FUNC_READ, COORD_TOP, 0, CELL_EMPTY);
      add_cmd(FUNC_STEP, 0, 0, CELL_EMPTY);
      add_cmd(FUNC_READ, 64, 64, CELL_EMPTY);
      add_cmd(FUNC_READ, 1, 1, CELL_EMPTY);

      wait_drained();
      repeat (16) @(posedge clock);
      if (fault_count == 0 && expected_replies.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lgs_pkg.sv
hw/rtl/lgs_row_ram.sv
hw/rtl/lgs_cell_rule.sv
hw/rtl/life_grid_generation_step.sv
test/tb.sv
